FILE: design/hcwp_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code word packer package
// Operation codes, fixed field widths and the queue entry type shared by the
// front end, the queue and the packer.
// ----------------------------------------------------------------------------
package hcwp_pkg;

  localparam int WORD_BITS   = 32;
  localparam int WIDE_BITS   = 2 * WORD_BITS;
  localparam int OP_BITS     = 2;
  localparam int SYM_BITS    = 8;
  localparam int CODE_BITS   = 24;
  localparam int LEN_BITS    = 5;
  localparam int FREE_BITS   = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [OP_BITS-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [LEN_BITS-1:0]  len;
  } table_entry_t;

  typedef struct packed {
    logic         flush;
    table_entry_t entry;
  } pack_cmd_t;

endpackage

FILE: design/hcwp_item_if.sv
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel that carries one load, encode or flush item.
// ----------------------------------------------------------------------------
interface hcwp_item_if;
  import hcwp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_BITS-1:0]   operation;
  logic [SYM_BITS-1:0]  symbol;
  logic [CODE_BITS-1:0] code_value;
  logic [LEN_BITS-1:0]  code_length;

  modport source (output valid, operation, symbol, code_value, code_length, input ready);
  modport sink (input valid, operation, symbol, code_value, code_length, output ready);
endinterface

FILE: design/hcwp_word_if.sv
// ----------------------------------------------------------------------------
// Packed word channel
// Valid/ready channel that carries one packed 32-bit word and its last flag.
// ----------------------------------------------------------------------------
interface hcwp_word_if;
  import hcwp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] packed_word;
  logic                 last_word;

  modport source (output valid, packed_word, last_word, input ready);
  modport sink (input valid, packed_word, last_word, output ready);
endinterface

FILE: design/huffman_code_word_packer_top.sv
// ----------------------------------------------------------------------------
// Huffman code word packer
// Loads a code table, packs the codes of encoded symbols MSB first into
// 32-bit words and emits a zero-padded last word on each flush.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload
//   items    in         operation, symbol, code_value, code_length
//   words    out        packed_word, last_word
//
// One item is accepted per cycle while items.ready is high; loads, encodes
// and flushes all stream back to back. A result passes through the table
// read register, the queue and the output register. The table is one
// memory with one write and one read port. Reset clears the accumulator
// and the queue but not the table. A stall on words fills the four-entry
// queue before items.ready drops.
module huffman_code_word_packer_top #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 24
) (
  input  logic      clk,
  input  logic      rst,
  hcwp_item_if.sink items,
  hcwp_word_if.source words
);
  import hcwp_pkg::*;

  logic      q_push;
  pack_cmd_t q_push_cmd;
  logic      q_full;
  logic      q_pop;
  pack_cmd_t q_pop_cmd;
  logic      q_valid;

  hcwp_front #(
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .q_push (q_push),
    .q_cmd  (q_push_cmd),
    .q_full (q_full)
  );

  hcwp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_pop_cmd),
    .not_empty (q_valid)
  );

  hcwp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_pop_cmd),
    .q_pop   (q_pop),
    .words   (words)
  );

`ifndef SYNTHESIS
  a_stall_only_when_queue_full: assert property (
    @(posedge clk) disable iff (rst) !items.ready |-> q_full
  ) else $error("items stalled while the queue had room");

  a_no_pop_into_blocked_output: assert property (
    @(posedge clk) disable iff (rst) (words.valid && !words.ready) |-> !q_pop
  ) else $error("packer advanced while the output word was stalled");

  a_pop_needs_entry: assert property (
    @(posedge clk) disable iff (rst) q_pop |-> q_valid
  ) else $error("packer popped an empty queue");
`endif

endmodule

FILE: design/hcwp_front.sv
// ----------------------------------------------------------------------------
// Huffman packer front end
// Accepts items, holds the code table, looks up encode symbols and hands
// encode and flush commands to the queue.
// ----------------------------------------------------------------------------
module hcwp_front #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  hcwp_item_if.sink             items,
  output logic                  q_push,
  output hcwp_pkg::pack_cmd_t   q_cmd,
  input  logic                  q_full
);
  import hcwp_pkg::*;

  localparam int IDX_BITS = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  table_entry_t code_table [SYMBOL_COUNT];
  table_entry_t rd_entry;
  table_entry_t wr_entry;
  logic         s1_valid;
  logic         s1_flush;

  logic                 accept;
  logic                 sym_ok;
  logic [IDX_BITS-1:0]  addr;
  logic [LEN_BITS-1:0]  len_sat;
  logic [CODE_BITS-1:0] code_mask;
  logic                 do_load;
  logic                 do_encode;
  logic                 do_flush;

  assign items.ready = !s1_valid || !q_full;
  assign accept      = items.valid && items.ready;
  assign sym_ok      = {1'b0, items.symbol} < (SYM_BITS + 1)'(SYMBOL_COUNT);
  assign addr        = items.symbol[IDX_BITS-1:0];

  // Lengths above the maximum saturate; code bits above the length are dropped.
  assign len_sat   = (items.code_length > LEN_BITS'(MAX_CODE_BITS)) ?
                     LEN_BITS'(MAX_CODE_BITS) : items.code_length;
  assign code_mask = ~({CODE_BITS{1'b1}} << len_sat);
  assign wr_entry  = '{code: items.code_value & code_mask, len: len_sat};

  always_comb begin
    do_load   = 1'b0;
    do_encode = 1'b0;
    do_flush  = 1'b0;
    unique case (items.operation)
      OP_LOAD:   do_load   = accept && sym_ok;
      OP_ENCODE: do_encode = accept && sym_ok;
      OP_FLUSH:  do_flush  = accept;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      code_table[addr] <= wr_entry;
    end
    if (do_encode) begin
      rd_entry <= code_table[addr];
    end
    if (items.ready) begin
      s1_flush <= do_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= do_encode || do_flush;
    end
  end

  assign q_push = s1_valid && !q_full;
  assign q_cmd  = '{flush: s1_flush, entry: rd_entry};

endmodule

FILE: design/hcwp_queue.sv
// ----------------------------------------------------------------------------
// Huffman packer command queue
// Short FIFO that decouples the table lookup from the bit packer.
// ----------------------------------------------------------------------------
module hcwp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  hcwp_pkg::pack_cmd_t   push_cmd,
  output logic                  full,
  input  logic                  pop,
  output hcwp_pkg::pack_cmd_t   pop_cmd,
  output logic                  not_empty
);
  import hcwp_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  pack_cmd_t           slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  logic do_push;
  logic do_pop;

  assign full      = (count == CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/hcwp_back.sv
// ----------------------------------------------------------------------------
// Huffman packer back end
// Appends codes to the bit accumulator and emits full or flushed words
// through an output register.
// ----------------------------------------------------------------------------
module hcwp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  hcwp_pkg::pack_cmd_t   q_cmd,
  output logic                  q_pop,
  hcwp_word_if.source           words
);
  import hcwp_pkg::*;

  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] acc_next;
  logic [FREE_BITS-1:0] free;
  logic [FREE_BITS-1:0] free_next;
  logic                 out_valid;
  logic [WORD_BITS-1:0] out_word;
  logic                 out_last;

  logic                 emit;
  logic [WORD_BITS-1:0] word_next;
  logic [FREE_BITS-1:0] len_ext;
  logic                 fits;
  logic [FREE_BITS-1:0] sh_fit;
  logic [FREE_BITS-1:0] rest;
  logic [WIDE_BITS-1:0] code_wide;
  logic [WIDE_BITS-1:0] fit_shifted;
  logic [WIDE_BITS-1:0] spill_shifted;

  assign q_pop = q_valid && (!out_valid || words.ready);

  assign len_ext       = {1'b0, q_cmd.entry.len};
  assign fits          = len_ext < free;
  assign sh_fit        = free - len_ext;
  assign rest          = len_ext - free;
  assign code_wide     = WIDE_BITS'(q_cmd.entry.code);
  assign fit_shifted   = code_wide << sh_fit;
  // Bits below the spill point land at the top of the fresh word; the rest shift out.
  assign spill_shifted = code_wide << (FREE_BITS'(WORD_BITS) - rest);

  always_comb begin
    emit      = 1'b0;
    word_next = acc;
    acc_next  = acc;
    free_next = free;
    priority if (q_cmd.flush) begin
      emit      = 1'b1;
      acc_next  = '0;
      free_next = FREE_BITS'(WORD_BITS);
    end else if (fits) begin
      acc_next  = acc | fit_shifted[WORD_BITS-1:0];
      free_next = sh_fit;
    end else begin
      emit      = 1'b1;
      word_next = acc | (WORD_BITS'(q_cmd.entry.code) >> rest);
      acc_next  = spill_shifted[WORD_BITS-1:0];
      free_next = FREE_BITS'(WORD_BITS) - rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      free      <= FREE_BITS'(WORD_BITS);
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        acc  <= acc_next;
        free <= free_next;
      end
      if (q_pop && emit) begin
        out_valid <= 1'b1;
      end else if (words.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_word <= word_next;
      out_last <= q_cmd.flush;
    end
  end

  assign words.valid       = out_valid;
  assign words.packed_word = out_word;
  assign words.last_word   = out_last;

endmodule
